FILE: src/rcpms_pkg.sv
// Shared types and constants for the RC pulse to motor speed decoder.
package rcpms_pkg;

    // Speed scaling
    localparam logic [11:0] CENTRE_US   = 12'd1500;
    localparam logic [7:0]  FULL_SPEED  = 8'd200;
    // floor(x / 5) = (x * DIV5_MULT) >> DIV5_SHIFT, exact for x below 2^18
    localparam logic [15:0] DIV5_MULT   = 16'd52429;
    localparam int          DIV5_SHIFT  = 18;

    // Measured widths are saturated to this many bits
    localparam int          WIDTH_BITS  = 13;
    localparam int          FIFO_DEPTH  = 4;
    localparam int          FIFO_AW     = $clog2(FIFO_DEPTH);

    // Register reset values
    localparam logic [11:0] RST_PULSE_MIN     = 12'd1000;
    localparam logic [11:0] RST_PULSE_MAX     = 12'd2000;
    localparam logic [11:0] RST_PULSE_NEUTRAL = 12'd1500;
    localparam logic [9:0]  RST_DEADBAND_HALF = 10'd50;
    localparam logic [11:0] RST_SNAP_LOW      = 12'd1150;
    localparam logic [11:0] RST_SNAP_HIGH     = 12'd1850;
    localparam logic [12:0] RST_MIRROR_SUM    = 13'd3000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PULSE_MIN     = 3'd0,
        REG_PULSE_MAX     = 3'd1,
        REG_PULSE_NEUTRAL = 3'd2,
        REG_DEADBAND_HALF = 3'd3,
        REG_SNAP_LOW      = 3'd4,
        REG_SNAP_HIGH     = 3'd5,
        REG_MIRROR_SUM    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
        logic [11:0] pulse_neutral;
        logic [9:0]  deadband_half;
        logic [11:0] snap_low;
        logic [11:0] snap_high;
        logic [12:0] mirror_sum;
    } cfg_t;

    // One classified edge, as queued between front and back
    typedef struct packed {
        logic                  chan;
        logic                  rising;
        logic [WIDTH_BITS-1:0] width;
    } evt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: src/rcpms_front.sv
// Front end: accepts pin edges, keeps rise timestamps and measures pulse widths.
module rcpms_front
    import rcpms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       chan,
    input  logic       pin_level,
    input  logic [31:0] time_us,
    input  fifo_stat_t fifo_st,
    output logic       push,
    output evt_t       push_evt
);

    logic [31:0] stamp_reg [2];
    logic [31:0] width_full;

    // Take a new edge whenever the queue has room
    assign s_tready = !fifo_st.full;
    assign push     = s_tvalid && s_tready;

    // Measure width modulo 2^32, saturate to the queued width
    always_comb
    begin
        width_full      = time_us - stamp_reg[chan];
        push_evt.chan   = chan;
        push_evt.rising = pin_level;
        if (|width_full[31:WIDTH_BITS])
        begin
            push_evt.width = {WIDTH_BITS{1'b1}};
        end
        else
        begin
            push_evt.width = width_full[WIDTH_BITS-1:0];
        end
    end

    // Store the timestamp of a rising edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg[0] <= '0;
            stamp_reg[1] <= '0;
        end
        else if (push && pin_level)
        begin
            stamp_reg[chan] <= time_us;
        end
    end

endmodule

FILE: src/rcpms_fifo.sv
// Short queue of classified edges between front and back.
module rcpms_fifo
    import rcpms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  evt_t       push_evt,
    input  logic       pop,
    output evt_t       head_evt,
    output fifo_stat_t fifo_st
);

    evt_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign head_evt      = mem_reg[rd_ptr_reg];
    assign fifo_st.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign fifo_st.empty = (count_reg == '0);

    // Write the entry at the tail
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_evt;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/rcpms_back.sv
// Back end: conditions widths into references and turns them into signed speeds.
module rcpms_back
    import rcpms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  evt_t       head_evt,
    input  fifo_stat_t fifo_st,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       out_chan,
    output logic [8:0] speed,
    output logic       updated
);

    logic [11:0] pulse_ref_reg [2];

    logic        a_valid_reg;
    logic        a_chan_reg;
    logic        a_upd_reg;
    logic [11:0] a_ref_reg;

    logic        out_valid_reg;
    logic        out_chan_reg;
    logic        out_upd_reg;
    logic [8:0]  out_speed_reg;

    logic        en;
    logic        in_range;
    logic        upd;
    logic [13:0] mirror_diff;
    logic signed [14:0] r_s;
    logic signed [14:0] mn_s;
    logic signed [14:0] mx_s;
    logic signed [14:0] lo_s;
    logic signed [14:0] hi_s;
    logic signed [14:0] nt_s;
    logic signed [14:0] sl_s;
    logic signed [14:0] sh_s;
    logic signed [14:0] snap_s;
    logic [11:0] new_ref;

    logic [11:0] ref_gap;
    logic [28:0] prod;
    logic [10:0] mag_raw;
    logic [7:0]  mag;
    logic [8:0]  speed_next;

    // Advance the pipeline whenever the output register is free or drained
    assign en  = !out_valid_reg || m_tready;
    assign pop = en && !fifo_st.empty;

    // Raw reference: width for left, mirrored width floored at zero for right
    always_comb
    begin
        in_range    = ({1'b0, cfg.pulse_min} <= head_evt.width) &&
                      (head_evt.width <= {1'b0, cfg.pulse_max});
        upd         = !head_evt.rising && (!head_evt.chan || in_range);
        mirror_diff = {1'b0, cfg.mirror_sum} - {1'b0, head_evt.width};
        if (!head_evt.chan)
        begin
            r_s = $signed({2'b00, head_evt.width});
        end
        else if (mirror_diff[13])
        begin
            r_s = '0;
        end
        else
        begin
            r_s = $signed({1'b0, mirror_diff});
        end
    end

    // Deadband and snap, then clamp to the limits with the low limit tested first
    always_comb
    begin
        mn_s = $signed({3'b000, cfg.pulse_min});
        mx_s = $signed({3'b000, cfg.pulse_max});
        nt_s = $signed({3'b000, cfg.pulse_neutral});
        sl_s = $signed({3'b000, cfg.snap_low});
        sh_s = $signed({3'b000, cfg.snap_high});
        lo_s = nt_s - $signed({5'b00000, cfg.deadband_half});
        hi_s = nt_s + $signed({5'b00000, cfg.deadband_half});
        if (r_s > lo_s && r_s < hi_s)
        begin
            snap_s = nt_s;
        end
        else if (r_s > sh_s && r_s < mx_s)
        begin
            snap_s = mx_s;
        end
        else if (r_s < sl_s && r_s > mn_s)
        begin
            snap_s = mn_s;
        end
        else
        begin
            snap_s = r_s;
        end
        if (snap_s < mn_s)
        begin
            new_ref = cfg.pulse_min;
        end
        else if (snap_s > mx_s)
        begin
            new_ref = cfg.pulse_max;
        end
        else
        begin
            new_ref = snap_s[11:0];
        end
    end

    // Hold references per channel and the conditioning stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ref_reg[0] <= CENTRE_US;
            pulse_ref_reg[1] <= CENTRE_US;
            a_valid_reg      <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pop;
            if (pop && upd)
            begin
                pulse_ref_reg[head_evt.chan] <= new_ref;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_chan_reg <= head_evt.chan;
            a_upd_reg  <= upd;
            a_ref_reg  <= upd ? new_ref : pulse_ref_reg[head_evt.chan];
        end
    end

    // Speed: |ref - centre| * 2 / 5, saturated, signed by side of centre
    always_comb
    begin
        if (a_ref_reg > CENTRE_US)
        begin
            ref_gap = a_ref_reg - CENTRE_US;
        end
        else
        begin
            ref_gap = CENTRE_US - a_ref_reg;
        end
        prod    = 29'({ref_gap, 1'b0}) * 29'(DIV5_MULT);
        mag_raw = prod[28:DIV5_SHIFT];
        if (mag_raw > 11'(FULL_SPEED))
        begin
            mag = FULL_SPEED;
        end
        else
        begin
            mag = mag_raw[7:0];
        end
        if (a_ref_reg <= CENTRE_US)
        begin
            speed_next = -{1'b0, mag};
        end
        else
        begin
            speed_next = {1'b0, mag};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && a_valid_reg)
        begin
            out_chan_reg  <= a_chan_reg;
            out_upd_reg   <= a_upd_reg;
            out_speed_reg <= speed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_chan = out_chan_reg;
    assign speed    = out_speed_reg;
    assign updated  = out_upd_reg;

endmodule

FILE: src/rc_pulse_to_motor_speed.sv
// Top level of the two-channel RC pulse width to signed motor speed decoder.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser[0] chan, tuser[1] pin_level, tdata[31:0] time_us
//  m_axis    out        tuser[0] out_chan, tdata[8:0] speed, tdata[9] updated
//  cfg       in         cfg_we, cfg_addr (register index), cfg_wdata
//
// One edge is accepted per cycle while the queue has room; a result passes through
// the queue entry, the conditioning stage and the output register.
// Reset clears the queue and pipeline valids, zeroes the rise timestamps and
// sets both references to 1500 us; configuration returns to its defaults.
// A stalled output holds the pipeline; the four-entry queue keeps taking edges
// until it fills, then s_tready drops.
module rc_pulse_to_motor_speed
    import rcpms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] time_us
    input  logic [1:0]  s_tuser,   // [0] chan, [1] pin_level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [8:0] speed, [9] updated, [15:10] zero
    output logic [0:0]  m_tuser,   // [0] out_chan
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);

    cfg_t       cfg_reg;
    fifo_stat_t fifo_st;
    logic       push;
    logic       pop;
    evt_t       push_evt;
    evt_t       head_evt;
    logic       out_chan;
    logic [8:0] speed;
    logic       updated;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_min     <= RST_PULSE_MIN;
            cfg_reg.pulse_max     <= RST_PULSE_MAX;
            cfg_reg.pulse_neutral <= RST_PULSE_NEUTRAL;
            cfg_reg.deadband_half <= RST_DEADBAND_HALF;
            cfg_reg.snap_low      <= RST_SNAP_LOW;
            cfg_reg.snap_high     <= RST_SNAP_HIGH;
            cfg_reg.mirror_sum    <= RST_MIRROR_SUM;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_PULSE_MIN:     cfg_reg.pulse_min     <= cfg_wdata[11:0];
                REG_PULSE_MAX:     cfg_reg.pulse_max     <= cfg_wdata[11:0];
                REG_PULSE_NEUTRAL: cfg_reg.pulse_neutral <= cfg_wdata[11:0];
                REG_DEADBAND_HALF: cfg_reg.deadband_half <= cfg_wdata[9:0];
                REG_SNAP_LOW:      cfg_reg.snap_low      <= cfg_wdata[11:0];
                REG_SNAP_HIGH:     cfg_reg.snap_high     <= cfg_wdata[11:0];
                REG_MIRROR_SUM:    cfg_reg.mirror_sum    <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    rcpms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .chan      (s_tuser[0]),
        .pin_level (s_tuser[1]),
        .time_us   (s_tdata),
        .fifo_st   (fifo_st),
        .push      (push),
        .push_evt  (push_evt)
    );

    rcpms_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_evt (push_evt),
        .pop      (pop),
        .head_evt (head_evt),
        .fifo_st  (fifo_st)
    );

    rcpms_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head_evt (head_evt),
        .fifo_st  (fifo_st),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_chan (out_chan),
        .speed    (speed),
        .updated  (updated)
    );

    assign m_tdata = {6'b000000, updated, speed};
    assign m_tuser = out_chan;

    // Speed never leaves the full-scale range
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(speed) <= 9'sd200 && $signed(speed) >= -9'sd200))
        else $error("speed out of range");

    // Queue is never both full and empty
    a_fifo_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_st.full && fifo_st.empty))
        else $error("queue status inconsistent");

    // A full queue refuses transfers
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_st.full |-> !push)
        else $error("push into full queue");

endmodule
